/* sv/peer_packet_admission_filter_defines.svh */
// Assertion macros shared by the peer packet admission filter.
// No dependencies; included by the top level only.
`ifndef PEER_PACKET_ADMISSION_FILTER_DEFINES_SVH
`define PEER_PACKET_ADMISSION_FILTER_DEFINES_SVH

// Condition cons must hold in the same cycle as ante.
`define PPAF_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Condition cons must hold in the cycle after ante.
`define PPAF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/ppaf_pkg.sv */
// Shared types and codes for the peer packet admission filter.
// No dependencies; used by the controller, the datapath and the top level.
package ppaf_pkg;

   localparam logic [1:0] KIND_SINGLE = 2'd0;
   localparam logic [1:0] KIND_START  = 2'd1;
   localparam logic [1:0] KIND_MIDDLE = 2'd2;
   localparam logic [1:0] KIND_END    = 2'd3;

   localparam logic [0:0] CSR_LATEST_ONLY    = 1'b0;
   localparam logic [0:0] CSR_PEER_CONNECTED = 1'b1;

   typedef enum logic [2:0] {
      VERDICT_QUEUED    = 3'd0,
      VERDICT_NOT_CONN  = 3'd1,
      VERDICT_REPLAY    = 3'd2,
      VERDICT_REFUSED   = 3'd3,
      VERDICT_ORPHAN    = 3'd4,
      VERDICT_FULL      = 3'd5,
      VERDICT_POPPED    = 3'd6,
      VERDICT_EMPTY     = 3'd7
   } verdict_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_FLUSH_ALL,
      ST_FLUSH_RUN,
      ST_ENQUEUE,
      ST_DONE
   } state_type;

   // Occupancy fields on the result channel.
   typedef logic [4:0] count_out_type;

   typedef struct packed {
      logic [31:0] seq;
      logic [1:0]  kind;
      logic [63:0] payload;
   } entry_type;

   typedef struct packed {
      logic        is_pop;
      logic        is_empty;
      logic        is_full;
      logic        connected;
      logic        replay;
      logic        ctrl;
      logic        latest;
      logic [1:0]  kind;
      logic        run_open;
      logic        seq_match;
      logic        has_complete;
      logic        head_match;
   } status_type;

   typedef struct packed {
      logic        latch_req;
      logic        count_rx;
      logic        count_replay;
      logic        count_drop;
      logic        raise_high;
      logic        set_run;
      logic        clear_run;
      logic        pop_head;
      logic        drop_head;
      logic        zero_complete;
      logic        enqueue;
      logic        set_verdict;
      verdict_type verdict;
      logic        load_rsp;
   } cmd_type;

   function automatic logic kind_is_complete(input logic [1:0] kind);
      return (kind == KIND_SINGLE) || (kind == KIND_END);
   endfunction

endpackage

/* sv/peer_packet_admission_filter.sv */
// A request is taken in the idle state and evaluated. If evaluation does not decide it,
// any needed flush of queued entries comes first, and then the enqueue step runs. The
// result then waits in the done state until the result register is free.
// Throughput: one item at a time. The next request can be taken in the cycle after the
// result is loaded.
// Reset (synchronous, active high) empties the queue, clears counters and run tracking.
`include "peer_packet_admission_filter_defines.svh"

module peer_packet_admission_filter #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [0:0]  csr_index,
   input  logic [0:0]  csr_write_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_mode,
   input  logic [1:0]  req_packet_kind,
   input  logic        req_control_flag,
   input  logic [31:0] req_sequence_number,
   input  logic [63:0] req_payload_word,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_verdict,
   output logic [4:0]  rsp_flushed_count,
   output logic [31:0] rsp_popped_sequence,
   output logic [1:0]  rsp_popped_kind,
   output logic [63:0] rsp_popped_payload,
   output logic [4:0]  rsp_queue_fill,
   output logic [4:0]  rsp_complete_count,
   output logic [31:0] rsp_received_total,
   output logic [31:0] rsp_dropped_total,
   output logic [31:0] rsp_replay_total
);

   ppaf_pkg::cmd_type    cmd;
   ppaf_pkg::status_type status;

   ppaf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   ppaf_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data),
      .req_mode            (req_mode),
      .req_packet_kind     (req_packet_kind),
      .req_control_flag    (req_control_flag),
      .req_sequence_number (req_sequence_number),
      .req_payload_word    (req_payload_word),
      .cmd                 (cmd),
      .status              (status),
      .rsp_verdict         (rsp_verdict),
      .rsp_flushed_count   (rsp_flushed_count),
      .rsp_popped_sequence (rsp_popped_sequence),
      .rsp_popped_kind     (rsp_popped_kind),
      .rsp_popped_payload  (rsp_popped_payload),
      .rsp_queue_fill      (rsp_queue_fill),
      .rsp_complete_count  (rsp_complete_count),
      .rsp_received_total  (rsp_received_total),
      .rsp_dropped_total   (rsp_dropped_total),
      .rsp_replay_total    (rsp_replay_total)
   );

   `PPAF_ASSERT_SAME(a_no_enqueue_when_full, clock, reset, cmd.enqueue,
                     !status.is_full, "enqueue into a full queue")
   `PPAF_ASSERT_SAME(a_no_drop_when_empty, clock, reset, cmd.pop_head || cmd.drop_head,
                     !status.is_empty, "head removed from an empty queue")
   `PPAF_ASSERT_SAME(a_result_slot_free, clock, reset, cmd.load_rsp,
                     !rsp_valid || rsp_ready, "result overwritten before its transfer")
   `PPAF_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready,
                     !req_ready && !cmd.load_rsp, "request taken while an item is in progress")

endmodule

/* sv/ppaf_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; holds the packet queue entries.
module ppaf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/ppaf_datapath.sv */
// Datapath of the admission filter: request latch, queue pointers, counters,
// configuration registers and result registers. Depends on ppaf_pkg, ppaf_ram.
module ppaf_datapath #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  logic [0:0]             csr_index,
   input  logic [0:0]             csr_write_data,
   input  logic                   req_mode,
   input  logic [1:0]             req_packet_kind,
   input  logic                   req_control_flag,
   input  logic [31:0]            req_sequence_number,
   input  logic [63:0]            req_payload_word,
   input  ppaf_pkg::cmd_type      cmd,
   output ppaf_pkg::status_type   status,
   output logic [2:0]             rsp_verdict,
   output logic [4:0]             rsp_flushed_count,
   output logic [31:0]            rsp_popped_sequence,
   output logic [1:0]             rsp_popped_kind,
   output logic [63:0]            rsp_popped_payload,
   output logic [4:0]             rsp_queue_fill,
   output logic [4:0]             rsp_complete_count,
   output logic [31:0]            rsp_received_total,
   output logic [31:0]            rsp_dropped_total,
   output logic [31:0]            rsp_replay_total
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int ENTRY_W = $bits(ppaf_pkg::entry_type);

   // Control state.
   logic [PTR_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0] complete_ff, complete_in;
   logic [31:0]      highest_ff, highest_in;
   logic             run_open_ff, run_open_in;
   logic [31:0]      run_seq_ff, run_seq_in;
   logic [31:0]      received_ff, received_in;
   logic [31:0]      dropped_ff, dropped_in;
   logic [31:0]      replay_ff, replay_in;
   logic             latest_ff, latest_in;
   logic             connected_ff, connected_in;

   // Payload registers.
   logic                  req_mode_ff, req_mode_in;
   logic [1:0]            req_kind_ff, req_kind_in;
   logic                  req_ctrl_ff, req_ctrl_in;
   logic [31:0]           req_seq_ff, req_seq_in;
   logic [63:0]           req_payload_ff, req_payload_in;
   logic [CNT_W-1:0]      flushed_ff, flushed_in;
   ppaf_pkg::entry_type   popped_ff, popped_in;
   ppaf_pkg::verdict_type verdict_ff, verdict_in;

   logic [2:0]            rsp_verdict_ff, rsp_verdict_in;
   logic [4:0]            rsp_flushed_ff, rsp_flushed_in;
   ppaf_pkg::entry_type   rsp_popped_ff, rsp_popped_in;
   logic [4:0]            rsp_fill_ff, rsp_fill_in;
   logic [4:0]            rsp_complete_ff, rsp_complete_in;
   logic [31:0]           rsp_received_ff, rsp_received_in;
   logic [31:0]           rsp_dropped_ff, rsp_dropped_in;
   logic [31:0]           rsp_replay_ff, rsp_replay_in;

   logic [PTR_W-1:0]      head_next;
   logic [PTR_W:0]        tail_sum;
   logic [PTR_W-1:0]      tail;
   logic [ENTRY_W-1:0]    rd_data;
   ppaf_pkg::entry_type   head_entry;
   ppaf_pkg::entry_type   wr_entry;

   assign head_next = (head_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
   assign tail_sum  = (PTR_W + 1)'(head_ff) + (PTR_W + 1)'(fill_ff);
   assign tail      = (tail_sum >= (PTR_W + 1)'(QUEUE_DEPTH))
                      ? PTR_W'(tail_sum - (PTR_W + 1)'(QUEUE_DEPTH))
                      : PTR_W'(tail_sum);

   assign wr_entry   = '{seq: req_seq_ff, kind: req_kind_ff, payload: req_payload_ff};
   assign head_entry = ppaf_pkg::entry_type'(rd_data);

   // The read address follows the next head, so the read data always shows
   // the entry at the current head, also as soon as the head pointer moves.
   ppaf_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue_ram (
      .clock   (clock),
      .wr_en   (cmd.enqueue),
      .wr_addr (tail),
      .wr_data (wr_entry),
      .rd_addr (head_in),
      .rd_data (rd_data)
   );

   always_comb begin
      status.is_pop       = req_mode_ff;
      status.is_empty     = (fill_ff == '0);
      status.is_full      = (fill_ff == CNT_W'(QUEUE_DEPTH));
      status.connected    = connected_ff;
      status.replay       = (req_seq_ff != '0) && (req_seq_ff < highest_ff);
      status.ctrl         = req_ctrl_ff;
      status.latest       = latest_ff;
      status.kind         = req_kind_ff;
      status.run_open     = run_open_ff;
      status.seq_match    = (req_seq_ff == run_seq_ff);
      status.has_complete = (complete_ff != '0);
      status.head_match   = (fill_ff != '0) && (head_entry.seq == run_seq_ff);
   end

   always_comb begin
      head_in        = head_ff;
      fill_in        = fill_ff;
      complete_in    = complete_ff;
      highest_in     = highest_ff;
      run_open_in    = run_open_ff;
      run_seq_in     = run_seq_ff;
      received_in    = received_ff;
      dropped_in     = dropped_ff;
      replay_in      = replay_ff;
      latest_in      = latest_ff;
      connected_in   = connected_ff;
      req_mode_in    = req_mode_ff;
      req_kind_in    = req_kind_ff;
      req_ctrl_in    = req_ctrl_ff;
      req_seq_in     = req_seq_ff;
      req_payload_in = req_payload_ff;
      flushed_in     = flushed_ff;
      popped_in      = popped_ff;
      verdict_in     = verdict_ff;

      rsp_verdict_in  = rsp_verdict_ff;
      rsp_flushed_in  = rsp_flushed_ff;
      rsp_popped_in   = rsp_popped_ff;
      rsp_fill_in     = rsp_fill_ff;
      rsp_complete_in = rsp_complete_ff;
      rsp_received_in = rsp_received_ff;
      rsp_dropped_in  = rsp_dropped_ff;
      rsp_replay_in   = rsp_replay_ff;

      if (csr_write_enable) begin
         unique case (csr_index)
            ppaf_pkg::CSR_LATEST_ONLY:    latest_in    = csr_write_data[0];
            ppaf_pkg::CSR_PEER_CONNECTED: connected_in = csr_write_data[0];
            default: ;
         endcase
      end

      if (cmd.latch_req) begin
         req_mode_in    = req_mode;
         req_kind_in    = req_packet_kind;
         req_ctrl_in    = req_control_flag;
         req_seq_in     = req_sequence_number;
         req_payload_in = req_payload_word;
         flushed_in     = '0;
         popped_in      = '0;
      end

      if (cmd.count_rx) begin
         received_in = received_ff + 1'b1;
      end
      if (cmd.count_replay) begin
         replay_in = replay_ff + 1'b1;
      end
      if (cmd.count_drop || cmd.drop_head) begin
         dropped_in = dropped_ff + 1'b1;
      end
      if (cmd.raise_high && (req_seq_ff > highest_ff)) begin
         highest_in = req_seq_ff;
      end
      if (cmd.set_run) begin
         run_open_in = 1'b1;
         run_seq_in  = req_seq_ff;
      end
      if (cmd.clear_run) begin
         run_open_in = 1'b0;
         run_seq_in  = '0;
      end

      if (cmd.pop_head || cmd.drop_head) begin
         head_in = head_next;
         fill_in = fill_ff - 1'b1;
         if (ppaf_pkg::kind_is_complete(head_entry.kind) && (complete_ff != '0)) begin
            complete_in = complete_ff - 1'b1;
         end
      end
      if (cmd.pop_head) begin
         popped_in = head_entry;
      end
      if (cmd.drop_head) begin
         flushed_in = flushed_ff + 1'b1;
      end
      if (cmd.zero_complete) begin
         complete_in = '0;
      end

      if (cmd.enqueue) begin
         fill_in = fill_ff + 1'b1;
         if (ppaf_pkg::kind_is_complete(req_kind_ff)) begin
            complete_in = complete_ff + 1'b1;
         end
      end

      if (cmd.set_verdict) begin
         verdict_in = cmd.verdict;
      end

      if (cmd.load_rsp) begin
         rsp_verdict_in  = verdict_ff;
         rsp_flushed_in  = ppaf_pkg::count_out_type'(flushed_ff);
         rsp_popped_in   = popped_ff;
         rsp_fill_in     = ppaf_pkg::count_out_type'(fill_ff);
         rsp_complete_in = ppaf_pkg::count_out_type'(complete_ff);
         rsp_received_in = received_ff;
         rsp_dropped_in  = dropped_ff;
         rsp_replay_in   = replay_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         fill_ff      <= '0;
         complete_ff  <= '0;
         highest_ff   <= '0;
         run_open_ff  <= 1'b0;
         run_seq_ff   <= '0;
         received_ff  <= '0;
         dropped_ff   <= '0;
         replay_ff    <= '0;
         latest_ff    <= 1'b0;
         connected_ff <= 1'b1;
      end else begin
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         complete_ff  <= complete_in;
         highest_ff   <= highest_in;
         run_open_ff  <= run_open_in;
         run_seq_ff   <= run_seq_in;
         received_ff  <= received_in;
         dropped_ff   <= dropped_in;
         replay_ff    <= replay_in;
         latest_ff    <= latest_in;
         connected_ff <= connected_in;
      end
   end

   always_ff @(posedge clock) begin
      req_mode_ff     <= req_mode_in;
      req_kind_ff     <= req_kind_in;
      req_ctrl_ff     <= req_ctrl_in;
      req_seq_ff      <= req_seq_in;
      req_payload_ff  <= req_payload_in;
      flushed_ff      <= flushed_in;
      popped_ff       <= popped_in;
      verdict_ff      <= verdict_in;
      rsp_verdict_ff  <= rsp_verdict_in;
      rsp_flushed_ff  <= rsp_flushed_in;
      rsp_popped_ff   <= rsp_popped_in;
      rsp_fill_ff     <= rsp_fill_in;
      rsp_complete_ff <= rsp_complete_in;
      rsp_received_ff <= rsp_received_in;
      rsp_dropped_ff  <= rsp_dropped_in;
      rsp_replay_ff   <= rsp_replay_in;
   end

   assign rsp_verdict         = rsp_verdict_ff;
   assign rsp_flushed_count   = rsp_flushed_ff;
   assign rsp_popped_sequence = rsp_popped_ff.seq;
   assign rsp_popped_kind     = rsp_popped_ff.kind;
   assign rsp_popped_payload  = rsp_popped_ff.payload;
   assign rsp_queue_fill      = rsp_fill_ff;
   assign rsp_complete_count  = rsp_complete_ff;
   assign rsp_received_total  = rsp_received_ff;
   assign rsp_dropped_total   = rsp_dropped_ff;
   assign rsp_replay_total    = rsp_replay_ff;

endmodule

/* sv/ppaf_ctrl.sv */
// Controller state machine of the admission filter: sequences evaluation,
// queue flushes, enqueue and result delivery. Depends on ppaf_pkg.
module ppaf_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  ppaf_pkg::status_type status,
   output ppaf_pkg::cmd_type    cmd
);

   ppaf_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ppaf_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      cmd.verdict = ppaf_pkg::VERDICT_QUEUED;
      req_ready = 1'b0;

      unique case (state_ff)
         ppaf_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               state_in      = ppaf_pkg::ST_EVAL;
            end
         end

         ppaf_pkg::ST_EVAL: begin
            if (status.is_pop) begin
               cmd.set_verdict = 1'b1;
               if (status.is_empty) begin
                  cmd.verdict = ppaf_pkg::VERDICT_EMPTY;
               end else begin
                  cmd.pop_head = 1'b1;
                  cmd.verdict  = ppaf_pkg::VERDICT_POPPED;
               end
               state_in = ppaf_pkg::ST_DONE;
            end else begin
               cmd.count_rx = 1'b1;
               if (!status.connected) begin
                  cmd.set_verdict = 1'b1;
                  cmd.verdict     = ppaf_pkg::VERDICT_NOT_CONN;
                  state_in        = ppaf_pkg::ST_DONE;
               end else if (status.replay) begin
                  cmd.count_replay = 1'b1;
                  cmd.set_verdict  = 1'b1;
                  cmd.verdict      = ppaf_pkg::VERDICT_REPLAY;
                  state_in         = ppaf_pkg::ST_DONE;
               end else begin
                  cmd.raise_high = 1'b1;
                  state_in       = ppaf_pkg::ST_ENQUEUE;
                  if (!status.ctrl) begin
                     if (status.latest) begin
                        if (status.kind != ppaf_pkg::KIND_SINGLE) begin
                           cmd.count_drop  = 1'b1;
                           cmd.clear_run   = 1'b1;
                           cmd.set_verdict = 1'b1;
                           cmd.verdict     = ppaf_pkg::VERDICT_REFUSED;
                           state_in        = ppaf_pkg::ST_DONE;
                        end else if (status.has_complete) begin
                           state_in = ppaf_pkg::ST_FLUSH_ALL;
                        end
                     end else if (status.kind == ppaf_pkg::KIND_START) begin
                        if (status.run_open) begin
                           state_in = ppaf_pkg::ST_FLUSH_RUN;
                        end
                     end else if (status.kind != ppaf_pkg::KIND_SINGLE) begin
                        if (!status.run_open || !status.seq_match) begin
                           cmd.count_drop  = 1'b1;
                           cmd.set_verdict = 1'b1;
                           cmd.verdict     = ppaf_pkg::VERDICT_ORPHAN;
                           state_in        = ppaf_pkg::ST_DONE;
                        end
                     end
                  end
               end
            end
         end

         // Discards every queued entry, one per cycle.
         ppaf_pkg::ST_FLUSH_ALL: begin
            if (!status.is_empty) begin
               cmd.drop_head = 1'b1;
            end else begin
               cmd.zero_complete = 1'b1;
               state_in          = ppaf_pkg::ST_ENQUEUE;
            end
         end

         // Discards head entries that belong to the abandoned fragment run.
         ppaf_pkg::ST_FLUSH_RUN: begin
            if (status.head_match) begin
               cmd.drop_head = 1'b1;
            end else begin
               state_in = ppaf_pkg::ST_ENQUEUE;
            end
         end

         ppaf_pkg::ST_ENQUEUE: begin
            if (!status.ctrl && !status.latest) begin
               cmd.set_run   = (status.kind == ppaf_pkg::KIND_START);
               cmd.clear_run = (status.kind == ppaf_pkg::KIND_END);
            end
            cmd.set_verdict = 1'b1;
            if (status.is_full) begin
               cmd.count_drop = 1'b1;
               cmd.verdict    = ppaf_pkg::VERDICT_FULL;
            end else begin
               cmd.enqueue = 1'b1;
               cmd.verdict = ppaf_pkg::VERDICT_QUEUED;
            end
            state_in = ppaf_pkg::ST_DONE;
         end

         // Waits until the result register is free, then loads it.
         ppaf_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               state_in     = ppaf_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = ppaf_pkg::ST_IDLE;
         end
      endcase

      rsp_valid_in = cmd.load_rsp || (rsp_valid_ff && !rsp_ready);
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
